// File: src/sng_pkg.sv
`default_nettype none
package sng_pkg;

	localparam int SNG_SAMPLE_WIDTH = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 17;
	localparam int GAIN_W = 17;
	localparam int HOLD_W = 16;

	localparam logic [GAIN_W-1:0] ONE_Q16 = 17'd65536;

	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RANGE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ATTACK = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RELEASE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_HOLD = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_COEFF = 3'd5;

	localparam logic [GAIN_W-1:0] RST_THRESHOLD = 17'd1024;
	localparam logic [GAIN_W-1:0] RST_RANGE = 17'd20724;
	localparam logic [GAIN_W-1:0] RST_ATTACK = 17'd1365;
	localparam logic [GAIN_W-1:0] RST_RELEASE = 17'd683;
	localparam logic [HOLD_W-1:0] RST_HOLD = 16'd96;
	localparam logic [GAIN_W-1:0] RST_COEFF = 17'd655;

	typedef enum logic [3:0] {
		PH_CLOSED = 4'b0001,
		PH_OPENING = 4'b0010,
		PH_OPEN = 4'b0100,
		PH_CLOSING = 4'b1000
	} gate_phase_t;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_ENV1 = 8'b0000_0010,
		ST_ENV2 = 8'b0000_0100,
		ST_GATE = 8'b0000_1000,
		ST_GAIN = 8'b0001_0000,
		ST_LEFT = 8'b0010_0000,
		ST_RIGHT = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} seq_state_t;

endpackage
`default_nettype wire

// File: src/sng_mac.sv
`default_nettype none
module sng_mac #(
	parameter int AW = 18,
	parameter int BW = 18
) (
	input  wire logic signed [AW-1:0]    a,
	input  wire logic signed [BW-1:0]    b,
	input  wire logic signed [AW+BW-1:0] addend,
	output logic signed [AW+BW-1:0]      result
);
	assign result = a * b + addend;
endmodule
`default_nettype wire

// File: src/stereo_noise_gate.sv
`default_nettype none
// Stereo noise gate. Each item carries a raw detect pair and a filtered audio pair
// and yields one gated audio pair. One shared multiply-add unit, stepped by a small
// sequencer, forms the envelope decay, the gain blend and both output scalings. After
// acceptance an item runs seven sequencer steps (two envelope steps, the gate update,
// the gain blend, two output scalings and the handoff to the output register), so
// in_ready returns only after that handoff, and no new item is taken before it; the
// handoff itself waits while a previous result still waits on out_ready. The output
// register lets the next item be accepted while a result is pending. Configuration
// writes are taken at any time with cfg_ready held high; write only while idle.
module stereo_noise_gate #(
	parameter int SAMPLE_WIDTH = sng_pkg::SNG_SAMPLE_WIDTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0]     left_detect,
	input  wire logic signed [SAMPLE_WIDTH-1:0]     right_detect,
	input  wire logic signed [SAMPLE_WIDTH-1:0]     left_audio,
	input  wire logic signed [SAMPLE_WIDTH-1:0]     right_audio,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]          left_out,
	output logic signed [SAMPLE_WIDTH-1:0]          right_out,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [sng_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [sng_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import sng_pkg::*;

	localparam int SW = SAMPLE_WIDTH;
	localparam int AW = ((SW > GAIN_W) ? SW : GAIN_W) + 1;
	localparam int BW = GAIN_W + 1;
	localparam int PW = AW + BW;
	localparam logic signed [PW-1:0] ROUND = PW'(32'sd32768);
	localparam logic signed [PW-1:0] SMAX = {{(PW-SW+1){1'b0}}, {(SW-1){1'b1}}};
	localparam logic signed [PW-1:0] SMIN = ~SMAX;

	logic [GAIN_W-1:0] thr_q, range_q, attack_q, release_q, coeff_q;
	logic [HOLD_W-1:0] hold_cfg_q;

	logic [GAIN_W-1:0] env_q, gate_q, gain_q, sum_q;
	logic [HOLD_W-1:0] hold_q;
	gate_phase_t phase_q;
	seq_state_t state_q;
	logic signed [SW-1:0] left_q, right_q, left_res_q, right_res_q;
	logic signed [PW-1:0] acc_q;
	logic out_valid_q;

	logic [SW-1:0] abs_l, abs_r;
	logic [15:0] mag_l, mag_r;
	logic [GAIN_W-1:0] coeff_c, cut_c;
	logic signed [AW-1:0] mac_a;
	logic signed [BW-1:0] mac_b;
	logic signed [PW-1:0] mac_add, mac_r, scaled;
	logic signed [SW-1:0] sat_c;
	logic above;
	logic [GAIN_W:0] gate_up;
	logic [GAIN_W-1:0] gate_down;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	assign abs_l = left_detect[SW-1] ? (~left_detect + 1'b1) : left_detect;
	assign abs_r = right_detect[SW-1] ? (~right_detect + 1'b1) : right_detect;

	generate
		if (SW > 16) begin : g_down
			assign mag_l = abs_l[SW-1:SW-16];
			assign mag_r = abs_r[SW-1:SW-16];
		end else if (SW == 16) begin : g_same
			assign mag_l = abs_l;
			assign mag_r = abs_r;
		end else begin : g_up
			assign mag_l = {abs_l, {(16-SW){1'b0}}};
			assign mag_r = {abs_r, {(16-SW){1'b0}}};
		end
	endgenerate

	assign coeff_c = (coeff_q > ONE_Q16) ? ONE_Q16 : coeff_q;
	assign cut_c = (range_q > ONE_Q16) ? ONE_Q16 : range_q;
	assign above = (env_q >= thr_q);
	assign gate_up = {1'b0, gate_q} + {1'b0, attack_q};
	assign gate_down = (gate_q > release_q) ? (gate_q - release_q) : '0;

	always_comb begin
		mac_a = '0;
		mac_b = '0;
		mac_add = ROUND;
		case (state_q)
			ST_ENV1: begin
				mac_a = $signed({{(AW-GAIN_W){1'b0}}, sum_q});
				mac_b = $signed({1'b0, coeff_c});
			end
			ST_ENV2: begin
				mac_a = $signed({{(AW-GAIN_W){1'b0}}, env_q});
				mac_b = $signed({1'b0, ONE_Q16 - coeff_c});
				mac_add = acc_q;
			end
			ST_GAIN: begin
				mac_a = $signed({{(AW-GAIN_W){1'b0}}, cut_c});
				mac_b = $signed({1'b0, ONE_Q16 - gate_q});
				mac_add = $signed({{(PW-GAIN_W-16){1'b0}}, gate_q, 16'b0}) + ROUND;
			end
			ST_LEFT: begin
				mac_a = $signed({{(AW-SW){left_q[SW-1]}}, left_q});
				mac_b = $signed({1'b0, gain_q});
			end
			ST_RIGHT: begin
				mac_a = $signed({{(AW-SW){right_q[SW-1]}}, right_q});
				mac_b = $signed({1'b0, gain_q});
			end
			default: begin
				mac_a = '0;
			end
		endcase
	end

	sng_mac #(
		.AW(AW),
		.BW(BW)
	) u_mac (
		.a(mac_a),
		.b(mac_b),
		.addend(mac_add),
		.result(mac_r)
	);

	assign scaled = mac_r >>> 16;
	assign sat_c = (scaled > SMAX) ? SMAX[SW-1:0] :
		(scaled < SMIN) ? SMIN[SW-1:0] : scaled[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= RST_THRESHOLD;
			range_q <= RST_RANGE;
			attack_q <= RST_ATTACK;
			release_q <= RST_RELEASE;
			hold_cfg_q <= RST_HOLD;
			coeff_q <= RST_COEFF;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q <= cfg_data;
				REG_RANGE: range_q <= cfg_data;
				REG_ATTACK: attack_q <= cfg_data;
				REG_RELEASE: release_q <= cfg_data;
				REG_HOLD: hold_cfg_q <= cfg_data[HOLD_W-1:0];
				REG_COEFF: coeff_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					sum_q <= {1'b0, mag_l} + {1'b0, mag_r};
					left_q <= left_audio;
					right_q <= right_audio;
				end
			end
			ST_ENV1: acc_q <= mac_r;
			ST_GAIN: gain_q <= mac_r[32:16];
			ST_LEFT: left_res_q <= sat_c;
			ST_RIGHT: right_res_q <= sat_c;
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					left_out <= left_res_q;
					right_out <= right_res_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_CLOSED;
			env_q <= '0;
			gate_q <= '0;
			hold_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_ENV1;
					end
				end
				ST_ENV1: state_q <= ST_ENV2;
				ST_ENV2: begin
					env_q <= (sum_q > env_q) ? sum_q : mac_r[32:16];
					state_q <= ST_GATE;
				end
				ST_GATE: begin
					case (phase_q)
						PH_CLOSED: begin
							if (above) begin
								phase_q <= PH_OPENING;
							end
						end
						PH_OPENING: begin
							if (gate_up >= {1'b0, ONE_Q16}) begin
								gate_q <= ONE_Q16;
								phase_q <= PH_OPEN;
								hold_q <= hold_cfg_q;
							end else begin
								gate_q <= gate_up[GAIN_W-1:0];
							end
						end
						PH_OPEN: begin
							if (hold_q == '0) begin
								if (!above) begin
									phase_q <= PH_CLOSING;
								end
							end else begin
								hold_q <= hold_q - 1'b1;
							end
						end
						PH_CLOSING: begin
							gate_q <= gate_down;
							if (above) begin
								phase_q <= PH_OPENING;
							end else if (gate_down == '0) begin
								phase_q <= PH_CLOSED;
							end
						end
						default: phase_q <= PH_CLOSED;
					endcase
					state_q <= ST_GAIN;
				end
				ST_GAIN: state_q <= ST_LEFT;
				ST_LEFT: state_q <= ST_RIGHT;
				ST_RIGHT: state_q <= ST_DONE;
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import sng_pkg::*;

	typedef logic signed [SNG_SAMPLE_WIDTH-1:0] sample_t;

	typedef struct {
		sample_t l;
		sample_t r;
	} out_pair_t;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [CFG_INDEX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		sample_t ld, rd, la, ra;
		bit typed;
		sample_t el, er;
	} stim_row_t;

	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_A = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_B = 3'd7;
	localparam longint UNITY = 65536;
	localparam longint HALF_LSB = 32768;
	localparam longint SAMPLE_MAX = 32767;
	localparam longint SAMPLE_MIN = -32768;
	localparam int LIMIT_CYCLES = 400000;
	localparam int SEGMENTS = 6;
	localparam int SEGMENT_ITEMS = 90;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	sample_t left_detect = '0;
	sample_t right_detect = '0;
	sample_t left_audio = '0;
	sample_t right_audio = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	sample_t left_out;
	sample_t right_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	stereo_noise_gate dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.left_detect(left_detect),
		.right_detect(right_detect),
		.left_audio(left_audio),
		.right_audio(right_audio),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_out(left_out),
		.right_out(right_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	longint thr_lvl, cut_cfg, atk_step, rel_step, hold_len, env_coef;
	longint env_lvl, gate_val, hold_cnt;
	gate_phase_t gate_ph;

	out_pair_t expected_pairs[$];
	out_pair_t seen_pair;
	stim_row_t directed_rows[$];
	int mismatch_cnt = 0;
	int cycle_cnt = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	function automatic sample_t scale_sample(sample_t s, longint g);
		longint p;
		p = (longint'(s) * g + HALF_LSB) >>> 16;
		if (p > SAMPLE_MAX)
			p = SAMPLE_MAX;
		else if (p < SAMPLE_MIN)
			p = SAMPLE_MIN;
		return sample_t'(p);
	endfunction

	task automatic advance_gate(input sample_t ld, rd, la, ra, output out_pair_t res);
		longint lvl_sum, c, cut, gain;
		bit above;
		lvl_sum = (ld < 0 ? -longint'(ld) : longint'(ld))
			+ (rd < 0 ? -longint'(rd) : longint'(rd));
		c = env_coef > UNITY ? UNITY : env_coef;
		cut = cut_cfg > UNITY ? UNITY : cut_cfg;
		if (lvl_sum > env_lvl) begin
			env_lvl = lvl_sum;
		end else begin
			env_lvl = (lvl_sum * c + env_lvl * (UNITY - c) + HALF_LSB) >> 16;
		end
		above = env_lvl >= thr_lvl;
		case (gate_ph)
			PH_CLOSED: begin
				if (above)
					gate_ph = PH_OPENING;
			end
			PH_OPENING: begin
				gate_val += atk_step;
				if (gate_val >= UNITY) begin
					gate_val = UNITY;
					gate_ph = PH_OPEN;
					hold_cnt = hold_len;
				end
			end
			PH_OPEN: begin
				if (hold_cnt == 0) begin
					if (!above)
						gate_ph = PH_CLOSING;
				end else begin
					hold_cnt--;
				end
			end
			PH_CLOSING: begin
				gate_val = gate_val > rel_step ? gate_val - rel_step : 0;
				if (above)
					gate_ph = PH_OPENING;
				else if (gate_val == 0)
					gate_ph = PH_CLOSED;
			end
			default: ;
		endcase
		gain = (cut * (UNITY - gate_val) + gate_val * UNITY + HALF_LSB) >> 16;
		res.l = scale_sample(la, gain);
		res.r = scale_sample(ra, gain);
	endtask

	task automatic send_item(input sample_t ld, rd, la, ra, input bit typed,
			input sample_t el, er);
		out_pair_t pr;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		left_detect = ld;
		right_detect = rd;
		left_audio = la;
		right_audio = ra;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		advance_gate(ld, rd, la, ra, pr);
		if (typed) begin
			pr.l = el;
			pr.r = er;
		end
		expected_pairs.push_back(pr);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid = 1'b0;
		while (expected_pairs.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_THRESHOLD: thr_lvl = data;
			REG_RANGE: cut_cfg = data;
			REG_ATTACK: atk_step = data;
			REG_RELEASE: rel_step = data;
			REG_HOLD: hold_len = data[HOLD_W-1:0];
			REG_COEFF: env_coef = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic stim_row_t item_row(sample_t ld, rd, la, ra, bit typed = 1'b0,
			sample_t el = '0, sample_t er = '0);
		stim_row_t row;
		row.kind = ROW_ITEM;
		row.idx = '0;
		row.data = '0;
		row.ld = ld;
		row.rd = rd;
		row.la = la;
		row.ra = ra;
		row.typed = typed;
		row.el = el;
		row.er = er;
		return row;
	endfunction

	function automatic stim_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		stim_row_t row;
		row = item_row('0, '0, '0, '0);
		row.kind = ROW_CFG;
		row.idx = idx;
		row.data = data;
		return row;
	endfunction

	function automatic sample_t rand_level(int lo, int hi);
		int m;
		m = $urandom_range(hi, lo);
		return sample_t'($urandom_range(0, 1) ? -m : m);
	endfunction

	task automatic program_setting(input bit hold_max);
		logic [CFG_DATA_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = 17'd0;
			1: v = 17'd65536;
			default: v = CFG_DATA_W'($urandom_range(12000, 300));
		endcase
		write_reg(REG_THRESHOLD, v);
		case ($urandom_range(0, 9))
			0: v = 17'd0;
			1: v = 17'd65536;
			2: v = CFG_DATA_W'($urandom_range(131071, 65537));
			default: v = CFG_DATA_W'($urandom_range(65535, 0));
		endcase
		write_reg(REG_RANGE, v);
		case ($urandom_range(0, 19))
			0: v = 17'd1;
			1: v = 17'd65536;
			2: v = 17'd131071;
			default: v = CFG_DATA_W'($urandom_range(40000, 1000));
		endcase
		write_reg(REG_ATTACK, v);
		case ($urandom_range(0, 19))
			0: v = 17'd1;
			1: v = 17'd65536;
			2: v = 17'd131071;
			default: v = CFG_DATA_W'($urandom_range(40000, 1000));
		endcase
		write_reg(REG_RELEASE, v);
		case ($urandom_range(0, 9))
			0: v[HOLD_W-1:0] = 16'd0;
			1: v[HOLD_W-1:0] = HOLD_W'($urandom_range(400, 100));
			default: v[HOLD_W-1:0] = HOLD_W'($urandom_range(20, 0));
		endcase
		if (hold_max)
			v[HOLD_W-1:0] = 16'hFFFF;
		v[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
		write_reg(REG_HOLD, v);
		case ($urandom_range(0, 9))
			0: v = 17'd0;
			1: v = 17'd65536;
			2: v = 17'd131071;
			default: v = CFG_DATA_W'($urandom_range(65535, 4000));
		endcase
		write_reg(REG_COEFF, v);
		write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B, CFG_DATA_W'($urandom));
	endtask

	task automatic run_segment();
		int burst_left;
		bit loud;
		sample_t ld, rd;
		burst_left = 0;
		loud = 1'b0;
		for (int n = 0; n < SEGMENT_ITEMS; n++) begin
			if (burst_left == 0) begin
				loud = !loud;
				burst_left = loud ? $urandom_range(30, 5) : $urandom_range(80, 20);
			end
			burst_left--;
			if ($urandom_range(0, 29) == 0)
				drain_results();
			if ($urandom_range(0, 9) == 0) begin
				ld = sample_t'($urandom);
				rd = sample_t'($urandom);
			end else if (loud) begin
				ld = rand_level(8000, 32767);
				rd = rand_level(8000, 32767);
			end else begin
				ld = rand_level(0, 200);
				rd = rand_level(0, 200);
			end
			send_item(ld, rd, sample_t'($urandom), sample_t'($urandom), 1'b0, '0, '0);
		end
	endtask

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_pairs.size() == 0) begin
				$display("%0t: unexpected item left_out %0d right_out %0d",
					$time, left_out, right_out);
				mismatch_cnt++;
			end else begin
				seen_pair = expected_pairs.pop_front();
				if (left_out !== seen_pair.l) begin
					$display("%0t: left_out expected %0d, got %0d",
						$time, seen_pair.l, left_out);
					mismatch_cnt++;
				end
				if (right_out !== seen_pair.r) begin
					$display("%0t: right_out expected %0d, got %0d",
						$time, seen_pair.r, right_out);
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin
		thr_lvl = RST_THRESHOLD;
		cut_cfg = RST_RANGE;
		atk_step = RST_ATTACK;
		rel_step = RST_RELEASE;
		hold_len = RST_HOLD;
		env_coef = RST_COEFF;
		env_lvl = 0;
		gate_val = 0;
		hold_cnt = 0;
		gate_ph = PH_CLOSED;

		directed_rows.push_back(item_row(0, 0, 32767, -32768, 1'b1, 10362, -10362));
		directed_rows.push_back(item_row(0, 0, -1, 1, 1'b1, 0, 0));
		directed_rows.push_back(item_row(-32768, -32768, 32767, -32768));
		directed_rows.push_back(cfg_row(REG_ATTACK, 17'd131071));
		directed_rows.push_back(cfg_row(REG_COEFF, 17'd131071));
		directed_rows.push_back(cfg_row(REG_HOLD, 17'd2));
		directed_rows.push_back(cfg_row(REG_UNUSED_A, 17'd0));
		directed_rows.push_back(item_row(32767, -32768, 12345, -12345));
		directed_rows.push_back(item_row(0, 0, -32768, 32767));
		directed_rows.push_back(item_row(0, 0, 1000, -1000));
		directed_rows.push_back(item_row(0, 0, 32767, 32767));
		directed_rows.push_back(cfg_row(REG_RELEASE, 17'd0));
		directed_rows.push_back(item_row(0, 0, -32768, -32768));
		directed_rows.push_back(cfg_row(REG_RELEASE, 17'd131071));
		directed_rows.push_back(cfg_row(REG_UNUSED_B, 17'd131071));
		directed_rows.push_back(item_row(100, -100, 20000, -20000));
		directed_rows.push_back(cfg_row(REG_RANGE, 17'd131071));
		directed_rows.push_back(item_row(0, 0, -32768, 32767));
		directed_rows.push_back(cfg_row(REG_RANGE, 17'd0));
		directed_rows.push_back(cfg_row(REG_THRESHOLD, 17'd0));
		directed_rows.push_back(item_row(0, 0, -32768, 32767));
		directed_rows.push_back(cfg_row(REG_ATTACK, 17'd0));
		directed_rows.push_back(item_row(0, 0, 16384, -16384));
		directed_rows.push_back(cfg_row(REG_ATTACK, 17'd30000));
		directed_rows.push_back(item_row(0, 0, 16384, -16384));
		directed_rows.push_back(item_row(0, 0, 16384, -16384));
		directed_rows.push_back(item_row(0, 0, 16384, -16384));
		directed_rows.push_back(cfg_row(REG_THRESHOLD, 17'd65536));
		directed_rows.push_back(cfg_row(REG_HOLD, 17'd0));
		directed_rows.push_back(cfg_row(REG_RELEASE, 17'd20000));
		directed_rows.push_back(item_row(0, 0, 300, -300));
		directed_rows.push_back(item_row(0, 0, 300, -300));
		directed_rows.push_back(item_row(0, 0, 300, -300));
		directed_rows.push_back(item_row(0, 0, 300, -300));
		directed_rows.push_back(item_row(-32768, -32768, 32767, 32767));
		directed_rows.push_back(item_row(0, 0, -32768, -32768));
		directed_rows.push_back(cfg_row(REG_COEFF, 17'd0));
		directed_rows.push_back(item_row(32767, 32767, -1, 1));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 24;
		rx_idle_pct = 55;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				drain_results();
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				send_item(directed_rows[i].ld, directed_rows[i].rd, directed_rows[i].la,
					directed_rows[i].ra, directed_rows[i].typed, directed_rows[i].el,
					directed_rows[i].er);
			end
		end

		for (int s = 0; s < SEGMENTS; s++) begin
			tx_idle_pct = s < 2 ? 24 : (s < 4 ? 55 : 0);
			rx_idle_pct = s < 2 ? 55 : (s < 4 ? 24 : 0);
			drain_results();
			program_setting(s == SEGMENTS - 1);
			run_segment();
		end

		drain_results();
		repeat (20) @(negedge clk);
		if (mismatch_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
